/* design/assert_macros.svh */
// Assertion macros shared by the discomfort classifier RTL.
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define DFC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define DFC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/dfc_pkg.sv */
// Package for the discomfort fuzzy classifier: widths, reset values,
// rule consequents, inter-module structs and membership edge helpers.
// No dependencies.
`timescale 1ns / 1ps

package dfc_pkg;

  // Field widths
  localparam int DiW      = 16;
  localparam int TempW    = 15;
  localparam int HumW     = 14;
  localparam int ScoreW   = 14;
  localparam int ClassW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Membership arithmetic
  localparam int              QuoW     = 16;
  localparam int              MembW    = 17;
  localparam int              OpW      = 17;
  localparam logic [MembW-1:0] Q16One  = 17'h10000;
  localparam int              NumLanes = 8;
  localparam int              NumRules = 9;

  // Discomfort index: M = N + 4630e6 + 500000 + 60000e6 >= 0, DI = M / 1e6 - 60000
  localparam int                NW       = 38;
  localparam logic signed [NW-1:0] NBias = 38'sd64630500000;
  localparam logic [30:0]       DiRecip  = 31'd1125899907;  // ceil(2^44 / 15625)
  localparam logic signed [18:0] DiShift = 19'sd60000;

  localparam logic [ScoreW-1:0] ScoreMax = 14'd12188;

  // Queue depths
  localparam int OutDepthDef = 32;
  localparam int MidDepthDef = 4;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DI_B0   = 3'd0,
    CFG_DI_B1   = 3'd1,
    CFG_DI_B2   = 3'd2,
    CFG_DI_B3   = 3'd3,
    CFG_TEMP_B0 = 3'd4,
    CFG_TEMP_B1 = 3'd5,
    CFG_TEMP_B2 = 3'd6,
    CFG_TEMP_B3 = 3'd7
  } cfg_idx_e;

  localparam logic [DiW-1:0]   DiBrkRst0   = 16'd7500;
  localparam logic [DiW-1:0]   DiBrkRst1   = 16'd8000;
  localparam logic [DiW-1:0]   DiBrkRst2   = 16'd8300;
  localparam logic [DiW-1:0]   DiBrkRst3   = 16'd8600;
  localparam logic [TempW-1:0] TempBrkRst0 = 15'd2400;
  localparam logic [TempW-1:0] TempBrkRst1 = 15'd2650;
  localparam logic [TempW-1:0] TempBrkRst2 = 15'd2850;
  localparam logic [TempW-1:0] TempBrkRst3 = 15'd3000;

  // Rule consequents, row = DI grade, column = temperature grade
  localparam logic [ScoreW-1:0] Conseq [NumRules] = '{
    14'd4097, 14'd9956, 14'd0, 14'd3600, 14'd8372, 14'd4508,
    14'd7759, 14'd7700, 14'd12188
  };

  typedef logic [3:0][DiW-1:0] brk_set_t;

  // One membership edge: either a fixed one, or num/den in Q16
  typedef struct packed {
    logic           one;
    logic [OpW-1:0] num;
    logic [OpW-1:0] den;
  } lane_op_t;

  typedef struct packed {
    logic signed [DiW-1:0]     di;
    lane_op_t [NumLanes-1:0]   ops;
  } front_item_t;

  typedef struct packed {
    logic signed [DiW-1:0] di;
    logic [ScoreW-1:0]     score;
    logic [ClassW-1:0]     cls;
  } result_t;

  // Rising edge between a and b
  function automatic lane_op_t rise_op(logic [DiW-1:0] x, logic [DiW-1:0] a,
                                       logic [DiW-1:0] b);
    lane_op_t op;
    logic signed [OpW-1:0] xs, as, bs;
    xs = {x[DiW-1], x};
    as = {a[DiW-1], a};
    bs = {b[DiW-1], b};
    op.one = 1'b0;
    op.num = '0;
    op.den = 17'd1;
    if (xs >= bs) begin
      op.one = 1'b1;
    end else if (xs > as) begin
      op.num = xs - as;
      op.den = bs - as;
    end
    return op;
  endfunction

  // Falling edge between a and b
  function automatic lane_op_t fall_op(logic [DiW-1:0] x, logic [DiW-1:0] a,
                                       logic [DiW-1:0] b);
    lane_op_t op;
    logic signed [OpW-1:0] xs, as, bs;
    xs = {x[DiW-1], x};
    as = {a[DiW-1], a};
    bs = {b[DiW-1], b};
    op.one = 1'b0;
    op.num = '0;
    op.den = 17'd1;
    if (xs >= bs) begin
      op.one = 1'b0;
    end else if (xs <= as) begin
      op.one = 1'b1;
    end else begin
      op.num = bs - xs;
      op.den = bs - as;
    end
    return op;
  endfunction

endpackage

/* design/dfc_fifo.sv */
// Small first-word-fall-through queue in flip-flops.
// Depends on nothing; used between front and back and at the result side.
`timescale 1ns / 1ps

module dfc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           data_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] cnt_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth+1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/dfc_front.sv */
// Front pipeline: discomfort index arithmetic and breakpoint classification.
// Depends on dfc_pkg; feeds the front-to-back queue.
`timescale 1ns / 1ps

module dfc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [dfc_pkg::TempW-1:0] temp_i,
  input  logic [dfc_pkg::HumW-1:0]       hum_i,
  input  dfc_pkg::brk_set_t              di_brk_i,
  input  dfc_pkg::brk_set_t              temp_brk_i,
  output logic                           valid_o,
  output dfc_pkg::front_item_t           item_o
);

  localparam int NW = dfc_pkg::NW;

  logic [5:0] v_q;

  // Stage 1: constant products of temperature
  logic signed [NW-1:0]          p1_q;
  logic signed [21:0]            u1_q;
  logic signed [dfc_pkg::TempW-1:0] t1_q;
  logic [dfc_pkg::HumW-1:0]      h1_q;
  // Stage 2: humidity product
  logic signed [NW-1:0]          p2_q, hu2_q;
  logic signed [dfc_pkg::TempW-1:0] t2_q;
  // Stage 3: biased sum, prescaled by 64
  logic [30:0]                   x3_q;
  logic signed [dfc_pkg::TempW-1:0] t3_q;
  // Stage 4: reciprocal multiply
  logic [17:0]                   q4_q;
  logic signed [dfc_pkg::TempW-1:0] t4_q;
  // Stage 5: saturated index
  logic signed [dfc_pkg::DiW-1:0] di5_q;
  logic signed [dfc_pkg::TempW-1:0] t5_q;
  // Stage 6: classified item
  dfc_pkg::front_item_t          item6_q;

  logic signed [NW-1:0]          m3_d;
  logic [61:0]                   prod4_d;
  logic signed [18:0]            di5_d;
  logic signed [dfc_pkg::DiW-1:0] di5_sat;
  logic [dfc_pkg::DiW-1:0]       tx;
  dfc_pkg::front_item_t          item6_d;

  always_comb begin
    m3_d    = p2_q + hu2_q + dfc_pkg::NBias;
    prod4_d = 62'(x3_q) * 62'(dfc_pkg::DiRecip);
    di5_d   = $signed({1'b0, q4_q}) - dfc_pkg::DiShift;
    if (di5_d > 19'sd32767) begin
      di5_sat = 16'sh7FFF;
    end else if (di5_d < -19'sd32768) begin
      di5_sat = 16'sh8000;
    end else begin
      di5_sat = di5_d[15:0];
    end
  end

  // Grade both inputs against their breakpoints
  always_comb begin
    tx = {t5_q[dfc_pkg::TempW-1], t5_q};
    item6_d.di     = di5_q;
    item6_d.ops[0] = dfc_pkg::fall_op(di5_q, di_brk_i[0], di_brk_i[1]);
    item6_d.ops[1] = dfc_pkg::rise_op(di5_q, di_brk_i[0], di_brk_i[1]);
    item6_d.ops[2] = dfc_pkg::fall_op(di5_q, di_brk_i[2], di_brk_i[3]);
    item6_d.ops[3] = dfc_pkg::rise_op(di5_q, di_brk_i[2], di_brk_i[3]);
    item6_d.ops[4] = dfc_pkg::fall_op(tx, temp_brk_i[0], temp_brk_i[1]);
    item6_d.ops[5] = dfc_pkg::rise_op(tx, temp_brk_i[0], temp_brk_i[1]);
    item6_d.ops[6] = dfc_pkg::fall_op(tx, temp_brk_i[2], temp_brk_i[3]);
    item6_d.ops[7] = dfc_pkg::rise_op(tx, temp_brk_i[2], temp_brk_i[3]);
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    p1_q    <= NW'(temp_i) * 38'sd810000;
    u1_q    <= 22'(temp_i) * 22'sd99 - 22'sd143000;
    t1_q    <= temp_i;
    h1_q    <= hum_i;
    p2_q    <= p1_q;
    hu2_q   <= NW'($signed({1'b0, h1_q}) * u1_q);
    t2_q    <= t1_q;
    x3_q    <= m3_d[36:6];
    t3_q    <= t2_q;
    q4_q    <= prod4_d[61:44];
    t4_q    <= t3_q;
    di5_q   <= di5_sat;
    t5_q    <= t4_q;
    item6_q <= item6_d;
  end

  assign valid_o = v_q[5];
  assign item_o  = item6_q;

endmodule

/* design/dfc_back.sv */
// Back pipeline: radix-2 ramp dividers, rule weights, score and class.
// Depends on dfc_pkg; fed from the front-to-back queue.
`timescale 1ns / 1ps

module dfc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  dfc_pkg::front_item_t item_i,
  output logic                 valid_o,
  output dfc_pkg::result_t     res_o
);

  localparam int Steps = dfc_pkg::QuoW;
  localparam int Lanes = dfc_pkg::NumLanes;
  localparam int OpW   = dfc_pkg::OpW;
  localparam int MembW = dfc_pkg::MembW;
  localparam int Rules = dfc_pkg::NumRules;

  logic [Steps-1:0]             dv_q;
  logic [OpW-1:0]               rem_q [Steps][Lanes];
  logic [Steps-1:0]             quo_q [Steps][Lanes];
  logic [OpW-1:0]               den_q [Steps][Lanes];
  logic                         one_q [Steps][Lanes];
  logic signed [dfc_pkg::DiW-1:0] ddi_q [Steps];

  // One quotient bit per stage for every lane
  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [OpW-1:0]   rem_in [Lanes];
    logic [Steps-1:0] quo_in [Lanes];
    logic [OpW-1:0]   den_in [Lanes];
    logic             one_in [Lanes];
    logic signed [dfc_pkg::DiW-1:0] di_in;
    logic             v_in;

    if (s == 0) begin : g_first
      always_comb begin
        v_in  = valid_i;
        di_in = item_i.di;
        for (int l = 0; l < Lanes; l++) begin
          rem_in[l] = item_i.ops[l].num;
          quo_in[l] = '0;
          den_in[l] = item_i.ops[l].den;
          one_in[l] = item_i.ops[l].one;
        end
      end
    end else begin : g_next
      always_comb begin
        v_in  = dv_q[s-1];
        di_in = ddi_q[s-1];
        for (int l = 0; l < Lanes; l++) begin
          rem_in[l] = rem_q[s-1][l];
          quo_in[l] = quo_q[s-1][l];
          den_in[l] = den_q[s-1][l];
          one_in[l] = one_q[s-1][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s] <= 1'b0;
      end else begin
        dv_q[s] <= v_in;
      end
    end

    // Shift, compare, subtract
    always_ff @(posedge clk_i) begin
      ddi_q[s] <= di_in;
      for (int l = 0; l < Lanes; l++) begin
        if ({rem_in[l], 1'b0} >= {1'b0, den_in[l]}) begin
          rem_q[s][l] <= OpW'({rem_in[l], 1'b0} - {1'b0, den_in[l]});
          quo_q[s][l] <= {quo_in[l][Steps-2:0], 1'b1};
        end else begin
          rem_q[s][l] <= OpW'({rem_in[l], 1'b0});
          quo_q[s][l] <= {quo_in[l][Steps-2:0], 1'b0};
        end
        den_q[s][l] <= den_in[l];
        one_q[s][l] <= one_in[l];
      end
    end
  end

  // Memberships and rule weights
  logic [MembW-1:0] memb [Lanes];
  logic [MembW-1:0] mdi [3];
  logic [MembW-1:0] mt [3];
  logic [2*MembW-1:0] w_q [Rules];
  logic [2*MembW+dfc_pkg::ScoreW-1:0] c_q [Rules];
  logic [49:0] g_q [3];
  logic [49:0] tot_q;
  logic signed [dfc_pkg::DiW-1:0] di_w_q, di_c_q, di_g_q, di_t_q;
  logic [3:0] sv_q;
  dfc_pkg::result_t res_q, res_d;
  logic [17:0] score_raw;
  logic [dfc_pkg::ScoreW-1:0] score;
  logic [dfc_pkg::ScoreW:0] cls_sum;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      memb[l] = one_q[Steps-1][l] ? dfc_pkg::Q16One : {1'b0, quo_q[Steps-1][l]};
    end
    mdi[0] = memb[0];
    mdi[1] = (memb[1] < memb[2]) ? memb[1] : memb[2];
    mdi[2] = memb[3];
    mt[0]  = memb[4];
    mt[1]  = (memb[5] < memb[6]) ? memb[5] : memb[6];
    mt[2]  = memb[7];
  end

  // Score, saturate and round to the class
  always_comb begin
    score_raw = tot_q[49:32];
    score     = (score_raw > 18'(dfc_pkg::ScoreMax)) ? dfc_pkg::ScoreMax
                                                     : score_raw[dfc_pkg::ScoreW-1:0];
    cls_sum   = {1'b0, score} + 15'd2048;
    res_d.di    = di_t_q;
    res_d.score = score;
    res_d.cls   = cls_sum[13:12];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q    <= '0;
      valid_o <= 1'b0;
    end else begin
      sv_q    <= {sv_q[2:0], dv_q[Steps-1]};
      valid_o <= sv_q[3];
    end
  end

  // Weight, consequent product, two-level sum, result
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        w_q[i*3+j] <= mdi[i] * mt[j];
      end
    end
    for (int k = 0; k < Rules; k++) begin
      c_q[k] <= w_q[k] * dfc_pkg::Conseq[k];
    end
    for (int g = 0; g < 3; g++) begin
      g_q[g] <= 50'(c_q[g*3]) + 50'(c_q[g*3+1]) + 50'(c_q[g*3+2]);
    end
    tot_q  <= g_q[0] + g_q[1] + g_q[2];
    di_w_q <= ddi_q[Steps-1];
    di_c_q <= di_w_q;
    di_g_q <= di_c_q;
    di_t_q <= di_g_q;
    res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule

/* design/discomfort_fuzzy_classifier_unit.sv */
// Top level of the discomfort fuzzy classifier: queue ports, breakpoint
// registers, front and back pipelines. Depends on dfc_pkg, dfc_fifo,
// dfc_front, dfc_back and assert_macros.svh.
//
//   Channel  Handshake          Payload
//   -------  -----------------  ----------------------------------------------
//   input    push / full        dry_temp_centi_i, humidity_centi_i
//   result   pop / empty        discomfort_centi_o, rule_score_q12_o,
//                               comfort_class_o
//   config   cfg_we_i           cfg_idx_i, cfg_data_i
//
// One transaction is taken per cycle while full is low; its result shows on
// the result ports after 6 front stages, the middle queue, 16 divider stages,
// 5 score stages and the result queue. Both pipelines run freely; full rises
// once OutDepth transactions are held inside, counting the ones still in
// flight, so nothing is ever dropped. Reset clears control and returns the
// breakpoints to their defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module discomfort_fuzzy_classifier_unit #(
  parameter int OutDepth = dfc_pkg::OutDepthDef,
  parameter int MidDepth = dfc_pkg::MidDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic signed [dfc_pkg::TempW-1:0]   dry_temp_centi_i,
  input  logic [dfc_pkg::HumW-1:0]           humidity_centi_i,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [dfc_pkg::DiW-1:0]     discomfort_centi_o,
  output logic [dfc_pkg::ScoreW-1:0]         rule_score_q12_o,
  output logic [dfc_pkg::ClassW-1:0]         comfort_class_o,
  input  logic                               cfg_we_i,
  input  logic [dfc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [dfc_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int CntW    = $clog2(OutDepth+1);
  localparam int MidCntW = $clog2(MidDepth+1);
  localparam int FrontW  = $bits(dfc_pkg::front_item_t);
  localparam int ResW    = $bits(dfc_pkg::result_t);

  logic [dfc_pkg::DiW-1:0]   di_brk_q [4];
  logic [dfc_pkg::TempW-1:0] temp_brk_q [4];
  dfc_pkg::brk_set_t         di_brk, temp_brk;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_acc, out_acc;

  logic                 front_v, back_v;
  dfc_pkg::front_item_t front_item, mid_item;
  logic                 mid_full, mid_empty;
  logic [MidCntW-1:0]   mid_cnt;
  dfc_pkg::result_t     back_res, out_res;
  logic                 out_full;
  logic [CntW-1:0]      out_cnt;

  // Write breakpoint registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      di_brk_q[0]   <= dfc_pkg::DiBrkRst0;
      di_brk_q[1]   <= dfc_pkg::DiBrkRst1;
      di_brk_q[2]   <= dfc_pkg::DiBrkRst2;
      di_brk_q[3]   <= dfc_pkg::DiBrkRst3;
      temp_brk_q[0] <= dfc_pkg::TempBrkRst0;
      temp_brk_q[1] <= dfc_pkg::TempBrkRst1;
      temp_brk_q[2] <= dfc_pkg::TempBrkRst2;
      temp_brk_q[3] <= dfc_pkg::TempBrkRst3;
    end else if (cfg_we_i) begin
      unique case (dfc_pkg::cfg_idx_e'(cfg_idx_i))
        dfc_pkg::CFG_DI_B0:   di_brk_q[0]   <= cfg_data_i;
        dfc_pkg::CFG_DI_B1:   di_brk_q[1]   <= cfg_data_i;
        dfc_pkg::CFG_DI_B2:   di_brk_q[2]   <= cfg_data_i;
        dfc_pkg::CFG_DI_B3:   di_brk_q[3]   <= cfg_data_i;
        dfc_pkg::CFG_TEMP_B0: temp_brk_q[0] <= cfg_data_i[dfc_pkg::TempW-1:0];
        dfc_pkg::CFG_TEMP_B1: temp_brk_q[1] <= cfg_data_i[dfc_pkg::TempW-1:0];
        dfc_pkg::CFG_TEMP_B2: temp_brk_q[2] <= cfg_data_i[dfc_pkg::TempW-1:0];
        dfc_pkg::CFG_TEMP_B3: temp_brk_q[3] <= cfg_data_i[dfc_pkg::TempW-1:0];
        default: ;
      endcase
    end
  end

  // Sign-extend temperature breakpoints to the common grading width
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      di_brk[b]   = di_brk_q[b];
      temp_brk[b] = {temp_brk_q[b][dfc_pkg::TempW-1], temp_brk_q[b]};
    end
  end

  // Track transactions held inside the block
  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;
  assign full    = (cnt_q == CntW'(OutDepth));

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  dfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_acc),
    .temp_i     (dry_temp_centi_i),
    .hum_i      (humidity_centi_i),
    .di_brk_i   (di_brk),
    .temp_brk_i (temp_brk),
    .valid_o    (front_v),
    .item_o     (front_item)
  );

  dfc_fifo #(
    .Width (FrontW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_v),
    .data_i  (front_item),
    .pop_i   (!mid_empty),
    .data_o  (mid_item),
    .full_o  (mid_full),
    .empty_o (mid_empty),
    .cnt_o   (mid_cnt)
  );

  dfc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!mid_empty),
    .item_i  (mid_item),
    .valid_o (back_v),
    .res_o   (back_res)
  );

  dfc_fifo #(
    .Width (ResW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_v),
    .data_i  (back_res),
    .pop_i   (pop),
    .data_o  (out_res),
    .full_o  (out_full),
    .empty_o (empty),
    .cnt_o   (out_cnt)
  );

  assign discomfort_centi_o = out_res.di;
  assign rule_score_q12_o   = out_res.score;
  assign comfort_class_o    = out_res.cls;

  // Checks on occupancy bookkeeping
  `DFC_ASSERT_ALWAYS(a_out_no_overflow, !(back_v && out_full), "result queue overflow")
  `DFC_ASSERT_ALWAYS(a_mid_no_overflow, !(front_v && mid_full), "middle queue overflow")
  `DFC_ASSERT_ALWAYS(a_out_within_count, out_cnt <= cnt_q, "more results than transactions")
  `DFC_ASSERT_IMPL(a_mid_shallow, !mid_empty, mid_cnt == MidCntW'(1), "middle queue backs up")

endmodule
